// File: rtl/ft_sensor_frame_deframer_core_macros.svh
// Assertion macros for the sensor frame deframer.
`ifndef FT_SENSOR_FRAME_DEFRAMER_CORE_MACROS_SVH
`define FT_SENSOR_FRAME_DEFRAMER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define FTD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer assertion failed");
// next-cycle implication
`define FTD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer assertion failed");
`else
`define FTD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define FTD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/ftd_pkg.sv
// Package: types, constants and helper functions of the sensor frame deframer.
package ftd_pkg;

   localparam int FLOAT_FRAME_BYTES = 28;
   localparam int INT_FRAME_BYTES   = 16;
   localparam int PAYLOAD_OFFSET    = 2;
   localparam int STORE_DEPTH       = 32;
   localparam int PAY_BYTES         = 24;

   localparam logic [7:0]  HDR_A             = 8'h20;
   localparam logic [7:0]  HDR_B             = 8'h4E;
   localparam logic [15:0] CRC_INIT          = 16'hFFFF;
   localparam logic [15:0] CRC_POLY          = 16'hA001;
   localparam logic [30:0] FORCE_LIMIT_BITS  = 31'h461C4000;
   localparam logic [30:0] TORQUE_LIMIT_BITS = 31'h447A0000;
   localparam logic [1:0]  RATE_FLOAT        = 2'd3;

   typedef struct packed {
      logic [7:0]  rx_byte;
      logic [31:0] time_stamp;
   } req_type;

   typedef struct packed {
      logic [31:0] force_x;
      logic [31:0] force_y;
      logic [31:0] force_z;
      logic [31:0] torque_x;
      logic [31:0] torque_y;
      logic [31:0] torque_z;
      logic        is_float;
      logic [31:0] sample_time;
      logic [31:0] error_total;
   } rsp_type;

   // one byte of Modbus CRC-16, reflected
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // finite and within magnitude limit, by bits
   function automatic logic float_ok(input logic [31:0] w, input logic [30:0] limit);
      logic [30:0] mag;
      mag = w[30:0];
      return (mag[30:23] != 8'hFF) && (mag <= limit);
   endfunction

   // saturating increment
   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

endpackage

// File: rtl/ft_sensor_frame_deframer_core.sv
// Top level of the sensor frame deframer: byte store, header search, CRC and (float frames) range check.
//
// Usage:
//   req_* carries one received byte and its time stamp per item (valid/stall).
//   rsp_* carries one decoded sample (valid/stall); most bytes give no sample.
//   csr_* writes rate_code (valid/ready); any write empties the store and clears
//   the error count. Write only while the block is idle.
// Bytes sit in a 32-entry circular store read through one registered port.
// Per byte: the byte is accepted, then a header scan runs over the filled part of the store.
// When a full frame lies behind the header, a check pass reads the frame
// (16 bytes integer, 28 float), then a verify step and an emit step.
// A failed frame drops one byte and the scan repeats, so a byte can take
// several scan/check passes; each pass is bounded by the frame length.
// A finished sample waits in the output register; the next byte is accepted
// meanwhile, and the block only holds at emit while the old sample is stalled.
// Reset (synchronous) empties the store, clears the count and sets rate 0.
`include "ft_sensor_frame_deframer_core_macros.svh"
module ft_sensor_frame_deframer_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ftd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ftd_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_data
);
   import ftd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CHECK,
      ST_VERIFY,
      ST_EMIT
   } state_type;

   state_type   state_ff;
   logic [1:0]  rate_ff;
   logic [4:0]  head_ff;
   logic [4:0]  fill_ff;
   logic [31:0] err_ff;
   logic [4:0]  ri_ff;
   logic        dv_ff;
   logic [4:0]  di_ff;
   logic [7:0]  prev_ff;
   logic [15:0] crc_ff;
   logic [7:0]  crc_lo_ff;
   logic [7:0]  crc_hi_ff;
   logic [31:0] stamp_ff;
   logic [7:0]  pay_ff [PAY_BYTES];
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   // frame store and its registered read port
   logic [7:0]  mem [STORE_DEPTH];
   logic [7:0]  rd_ff;
   logic [4:0]  raddr;
   logic [4:0]  waddr;

   logic        req_fire;
   logic        csr_fire;
   logic        is_flt;
   logic [4:0]  frame_len;
   logic        issue;
   logic        found;
   logic        scan_end;
   logic [4:0]  pos;
   logic [4:0]  pay_idx;
   logic        crc_good;
   logic        vals_ok;
   logic [31:0] vals [6];
   logic [4:0]  fill_in;
   logic        emit_go;

   assign req_fire  = req_valid && !req_stall;
   assign csr_fire  = csr_valid && csr_ready;
   assign req_stall = (state_ff != ST_IDLE) || csr_valid;
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign emit_go   = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   assign is_flt    = (rate_ff == RATE_FLOAT);
   assign frame_len = is_flt ? 5'(FLOAT_FRAME_BYTES) : 5'(INT_FRAME_BYTES);
   assign raddr     = head_ff + ri_ff;
   assign waddr     = head_ff + fill_ff;
   assign issue     = (state_ff == ST_SCAN) ? (ri_ff < fill_ff) : (ri_ff < frame_len);

   // header search on the byte stream coming back from the store
   assign found    = dv_ff && (di_ff != 5'd0) && (prev_ff == HDR_A) && (rd_ff == HDR_B);
   assign pos      = di_ff - 5'd1;
   assign scan_end = dv_ff && (di_ff == fill_ff - 5'd1);
   assign pay_idx  = di_ff - 5'(PAYLOAD_OFFSET);
   assign fill_in  = fill_ff - pos;

   // sample words and plausibility
   always_comb begin
      vals_ok = 1'b1;
      for (int k = 0; k < 6; k++) begin
         if (is_flt) begin
            vals[k] = {pay_ff[4*k], pay_ff[4*k+1], pay_ff[4*k+2], pay_ff[4*k+3]};
            if (!float_ok(vals[k], (k < 3) ? FORCE_LIMIT_BITS : TORQUE_LIMIT_BITS)) begin
               vals_ok = 1'b0;
            end
         end else begin
            vals[k] = {{16{pay_ff[2*k+1][7]}}, pay_ff[2*k+1], pay_ff[2*k]};
         end
      end
   end
   assign crc_good = (crc_ff == {crc_hi_ff, crc_lo_ff});

   // store write and read
   always_ff @(posedge clock) begin
      if (req_fire) begin
         mem[waddr] <= req_data.rx_byte;
      end
      rd_ff <= mem[raddr];
   end

   // payload capture during the check pass
   always_ff @(posedge clock) begin
      if (state_ff == ST_CHECK && dv_ff && di_ff >= 5'(PAYLOAD_OFFSET)
          && pay_idx < 5'(PAY_BYTES)) begin
         pay_ff[pay_idx] <= rd_ff;
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rate_ff      <= 2'd0;
         head_ff      <= 5'd0;
         fill_ff      <= 5'd0;
         err_ff       <= 32'd0;
         ri_ff        <= 5'd0;
         dv_ff        <= 1'b0;
         di_ff        <= 5'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // emit sets valid itself, so the drain applies only in other states
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         dv_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (csr_fire) begin
                  rate_ff <= csr_data;
                  fill_ff <= 5'd0;
                  err_ff  <= 32'd0;
               end else if (req_fire) begin
                  fill_ff  <= fill_ff + 5'd1;
                  stamp_ff <= req_data.time_stamp;
                  ri_ff    <= 5'd0;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (issue) begin
                  ri_ff <= ri_ff + 5'd1;
               end
               dv_ff   <= issue;
               di_ff   <= ri_ff;
               prev_ff <= rd_ff;
               if (found) begin
                  if (pos != 5'd0) begin
                     err_ff  <= sat_inc(err_ff);
                     head_ff <= head_ff + pos;
                     fill_ff <= fill_in;
                  end
                  ri_ff    <= 5'd0;
                  dv_ff    <= 1'b0;
                  crc_ff   <= CRC_INIT;
                  state_ff <= (fill_in < frame_len) ? ST_IDLE : ST_CHECK;
               end else if (fill_ff <= 5'd1) begin
                  state_ff <= ST_IDLE;
               end else if (scan_end) begin
                  err_ff <= sat_inc(err_ff);
                  if (rd_ff == HDR_A) begin
                     head_ff <= head_ff + fill_ff - 5'd1;
                     fill_ff <= 5'd1;
                  end else begin
                     fill_ff <= 5'd0;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            ST_CHECK: begin
               if (issue) begin
                  ri_ff <= ri_ff + 5'd1;
               end
               dv_ff <= issue;
               di_ff <= ri_ff;
               if (dv_ff) begin
                  if (di_ff < frame_len - 5'd2) begin
                     crc_ff <= crc_byte(crc_ff, rd_ff);
                  end else if (di_ff == frame_len - 5'd2) begin
                     crc_lo_ff <= rd_ff;
                  end else begin
                     crc_hi_ff <= rd_ff;
                     state_ff  <= ST_VERIFY;
                  end
               end
            end
            ST_VERIFY: begin
               if (crc_good && vals_ok) begin
                  state_ff <= ST_EMIT;
               end else begin
                  err_ff   <= sat_inc(err_ff);
                  head_ff  <= head_ff + 5'd1;
                  fill_ff  <= fill_ff - 5'd1;
                  ri_ff    <= 5'd0;
                  state_ff <= ST_SCAN;
               end
            end
            ST_EMIT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  head_ff      <= head_ff + frame_len;
                  fill_ff      <= fill_ff - frame_len;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (state_ff == ST_EMIT && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_ff.force_x     <= vals[0];
         rsp_ff.force_y     <= vals[1];
         rsp_ff.force_z     <= vals[2];
         rsp_ff.torque_x    <= vals[3];
         rsp_ff.torque_y    <= vals[4];
         rsp_ff.torque_z    <= vals[5];
         rsp_ff.is_float    <= is_flt;
         rsp_ff.sample_time <= stamp_ff;
         rsp_ff.error_total <= err_ff;
      end
   end

   // checks
   `FTD_ASSERT_IMP(a_fill_bound, clock, reset, 1'b1, fill_ff <= 5'(FLOAT_FRAME_BYTES))
   `FTD_ASSERT_NEXT(a_accept_scans, clock, reset, req_fire, state_ff == ST_SCAN)
   `FTD_ASSERT_NEXT(a_emit_shows, clock, reset, emit_go, rsp_valid_ff)
   `FTD_ASSERT_NEXT(a_count_grows, clock, reset, !csr_fire, err_ff >= $past(err_ff))

endmodule
